// File: src/magb_pkg.sv
// shared types, constants and helpers for the magnetometer bias calibration block
// no dependencies
`default_nettype none

package magb_pkg;

  localparam int unsigned SAMPLES_PER_PHASE = 10;
  localparam int unsigned SCALE_FRAC_BITS = 12;

  localparam int unsigned RAW_W = 16;
  localparam int unsigned TOTAL_W = 24;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned PROD_W = RAW_W + SCALE_W + 1;
  localparam int unsigned DEN_W = TOTAL_W + 2;
  localparam int unsigned AXES = 3;
  localparam int unsigned AX_W = 2;

  localparam longint unsigned K_XY_NUM =
    64'(7656) * 64'(SAMPLES_PER_PHASE) * (64'(1) << SCALE_FRAC_BITS);
  localparam longint unsigned K_Z_NUM =
    64'(7128) * 64'(SAMPLES_PER_PHASE) * (64'(1) << SCALE_FRAC_BITS);
  localparam int unsigned NUM_W = $clog2(K_XY_NUM + 1);
  localparam int unsigned CNT_W = $clog2(NUM_W);

  localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(64'(1) << SCALE_FRAC_BITS);
  localparam logic signed [RAW_W-1:0] SAT_LIMIT = -16'sd4096;
  localparam logic [AX_W-1:0] AX_X = 2'd0;
  localparam logic [AX_W-1:0] AX_Z = 2'd2;
  localparam logic [AX_W-1:0] AX_LAST = AX_W'(AXES - 1);

  typedef enum logic [2:0] {
    OP_START    = 3'd0,
    OP_POS      = 3'd1,
    OP_NEG      = 3'd2,
    OP_FINISH   = 3'd3,
    OP_MEASURE  = 3'd4
  } op_e;

  typedef struct packed {
    logic sub;
    logic capture;
  } magb_unit_req_t;

  typedef struct packed {
    logic            start;
    logic [AX_W-1:0] axis;
  } magb_div_req_t;

  function automatic logic [NUM_W-1:0] k_num(input logic [AX_W-1:0] axis);
    logic [NUM_W-1:0] k;
    case (axis)
      AX_Z:    k = NUM_W'(K_Z_NUM);
      default: k = NUM_W'(K_XY_NUM);
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// File: src/magnetometer_bias_calibration_top.sv
// top level: sequencer, calibration state and stream ports
// depends on magb_pkg, magb_axis_unit, magb_div
`default_nettype none

// Three-axis magnetometer self-test calibration. Each request on the input stream
// (op in tuser: start, positive-bias sample, negative-bias sample, finish, measure)
// produces exactly one result on the output stream: x/y/z in tdata and the
// calibration error flag in tuser. Requests are handled one at a time; the axes go
// one after another through one shared add/multiply unit and one serial divider.
// The divider makes one quotient bit per cycle. A new request is taken while
// the previous result still waits in the output register.
module magnetometer_bias_calibration_top
  import magb_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [47:0] s_axis_tdata_i,   // x_raw, y_raw, z_raw
  input  wire logic [2:0]  s_axis_tuser_i,   // op
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o,   // x_out, y_out, z_out
  output logic [0:0]       m_axis_tuser_o    // cal_error
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_ACC  = 7'b0000010,
    ST_MUL  = 7'b0000100,
    ST_SCL  = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_DIVW = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_e;

  state_e                     state_q, state_d;
  op_e                        op_q, op_d;
  logic [AX_W-1:0]            ax_q, ax_d;
  logic signed [TOTAL_W-1:0]  totals_q [AXES];
  logic signed [TOTAL_W-1:0]  totals_d [AXES];
  logic [SCALE_W-1:0]         scales_q [AXES];
  logic [SCALE_W-1:0]         scales_d [AXES];
  logic                       flag_q, flag_d;
  logic signed [RAW_W-1:0]    raw_q [AXES];
  logic signed [RAW_W-1:0]    raw_d [AXES];
  logic [RAW_W-1:0]           res_q [AXES];
  logic [RAW_W-1:0]           res_d [AXES];
  logic                       m_valid_q, m_valid_d;
  logic [47:0]                m_data_q, m_data_d;
  logic                       m_user_q, m_user_d;

  magb_unit_req_t             unit_req;
  logic signed [TOTAL_W-1:0]  unit_total;
  logic signed [RAW_W-1:0]    unit_scaled;
  magb_div_req_t              div_req;
  logic                       div_done;
  logic [SCALE_W-1:0]         div_quot;
  logic [TOTAL_W-1:0]         mag;
  logic                       accept;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;
  assign mag = totals_q[ax_q][TOTAL_W-1] ? TOTAL_W'(-totals_q[ax_q]) : TOTAL_W'(totals_q[ax_q]);

  magb_axis_unit u_unit (
    .clk_i    (clk_i),
    .req_i    (unit_req),
    .raw_i    (raw_q[ax_q]),
    .total_i  (totals_q[ax_q]),
    .scale_i  (scales_q[ax_q]),
    .total_o  (unit_total),
    .scaled_o (unit_scaled)
  );

  magb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .mag_i  (mag),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    ax_d      = ax_q;
    totals_d  = totals_q;
    scales_d  = scales_q;
    flag_d    = flag_q;
    raw_d     = raw_q;
    res_d     = res_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    unit_req  = '0;
    div_req   = '0;
    div_req.axis = ax_q;

    if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d     = op_e'(s_axis_tuser_i);
          raw_d[0] = s_axis_tdata_i[15:0];
          raw_d[1] = s_axis_tdata_i[31:16];
          raw_d[2] = s_axis_tdata_i[47:32];
          ax_d     = AX_X;
          res_d    = '{default: '0};
          case (op_e'(s_axis_tuser_i))
            OP_START: begin
              totals_d = '{default: '0};
              scales_d = '{default: SCALE_ONE};
              flag_d   = 1'b0;
              state_d  = ST_OUT;
            end
            OP_POS, OP_NEG: state_d = ST_ACC;
            OP_FINISH:      state_d = ST_DIV;
            OP_MEASURE:     state_d = ST_MUL;
            default:        state_d = ST_OUT;
          endcase
        end
      end
      ST_ACC: begin
        unit_req.sub   = (op_q == OP_NEG);
        totals_d[ax_q] = unit_total;
        if (raw_q[ax_q] <= SAT_LIMIT) begin
          flag_d = 1'b1;
        end
        if (ax_q == AX_LAST) begin
          state_d = ST_OUT;
        end else begin
          ax_d = ax_q + 1'b1;
        end
      end
      ST_MUL: begin
        unit_req.capture = 1'b1;
        state_d          = ST_SCL;
      end
      ST_SCL: begin
        res_d[ax_q] = unit_scaled;
        if (ax_q == AX_LAST) begin
          state_d = ST_OUT;
        end else begin
          ax_d    = ax_q + 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_DIV: begin
        if (flag_q || (totals_q[ax_q] == '0)) begin
          res_d[ax_q] = scales_q[ax_q];
          if (ax_q == AX_LAST) begin
            state_d = ST_OUT;
          end else begin
            ax_d = ax_q + 1'b1;
          end
        end else begin
          div_req.start = 1'b1;
          state_d       = ST_DIVW;
        end
      end
      ST_DIVW: begin
        if (div_done) begin
          scales_d[ax_q] = div_quot;
          res_d[ax_q]    = div_quot;
          if (ax_q == AX_LAST) begin
            state_d = ST_OUT;
          end else begin
            ax_d    = ax_q + 1'b1;
            state_d = ST_DIV;
          end
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {res_q[2], res_q[1], res_q[0]};
          m_user_d  = flag_q;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ax_q      <= AX_X;
      totals_q  <= '{default: '0};
      scales_q  <= '{default: SCALE_ONE};
      flag_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ax_q      <= ax_d;
      totals_q  <= totals_d;
      scales_q  <= scales_d;
      flag_q    <= flag_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    raw_q    <= raw_d;
    res_q    <= res_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

`default_nettype wire

// File: src/magb_div.sv
// serial restoring divider: scale = K numerator / (5 * |total|), saturated to 16 bits
// one quotient bit per cycle; depends on magb_pkg
`default_nettype none

module magb_div
  import magb_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire magb_div_req_t         req_i,
  input  wire logic [TOTAL_W-1:0]    mag_i,
  output logic                       done_o,
  output logic [SCALE_W-1:0]         quot_o
);

  logic                busy_q;
  logic                done_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [NUM_W-1:0]    num_q;
  logic [DEN_W-1:0]    rem_q;
  logic [DEN_W-1:0]    den_q;
  logic [DEN_W-1:0]    den_d;
  logic [DEN_W:0]      shifted;
  logic [DEN_W:0]      diff;
  logic                ge;

  assign den_d   = ({2'b00, mag_i} << 2) + {2'b00, mag_i};
  assign shifted = {rem_q, num_q[NUM_W-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= k_num(req_i.axis);
      rem_q <= '0;
      den_q <= den_d;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], ge};
      rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = (|num_q[NUM_W-1:SCALE_W]) ? {SCALE_W{1'b1}} : num_q[SCALE_W-1:0];

endmodule

`default_nettype wire

// File: src/magb_axis_unit.sv
// shared per-axis datapath: saturating total add/subtract and raw times scale
// depends on magb_pkg
`default_nettype none

module magb_axis_unit
  import magb_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire magb_unit_req_t             req_i,
  input  wire logic signed [RAW_W-1:0]    raw_i,
  input  wire logic signed [TOTAL_W-1:0]  total_i,
  input  wire logic [SCALE_W-1:0]         scale_i,
  output logic signed [TOTAL_W-1:0]       total_o,
  output logic signed [RAW_W-1:0]         scaled_o
);

  localparam logic signed [PROD_W-1:0] FRAC_MASK =
    PROD_W'((64'(1) << SCALE_FRAC_BITS) - 1);
  localparam logic signed [PROD_W-1:0] OUT_MAX = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] OUT_MIN = -PROD_W'(32768);

  logic signed [TOTAL_W:0]   sum;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [PROD_W-1:0]  adj;
  logic signed [PROD_W-1:0]  shr;

  assign sum = req_i.sub ? (TOTAL_W+1)'(total_i) - (TOTAL_W+1)'(raw_i)
                         : (TOTAL_W+1)'(total_i) + (TOTAL_W+1)'(raw_i);

  always_comb begin
    if (sum[TOTAL_W] != sum[TOTAL_W-1]) begin
      total_o = sum[TOTAL_W] ? {1'b1, {(TOTAL_W-1){1'b0}}} : {1'b0, {(TOTAL_W-1){1'b1}}};
    end else begin
      total_o = sum[TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.capture) begin
      prod_q <= PROD_W'(raw_i) * $signed({1'b0, scale_i});
    end
  end

  // round toward zero for negative products
  assign adj = prod_q[PROD_W-1] ? prod_q + FRAC_MASK : prod_q;
  assign shr = adj >>> SCALE_FRAC_BITS;

  always_comb begin
    if (shr > OUT_MAX) begin
      scaled_o = 16'sh7FFF;
    end else if (shr < OUT_MIN) begin
      scaled_o = -16'sh8000;
    end else begin
      scaled_o = shr[RAW_W-1:0];
    end
  end

endmodule

`default_nettype wire
